@@ rtl/bcl_pkg.sv @@
// Package for the bank controller with clock latch.
// Holds field widths, function and region codes, and the control write and status structs.
// Depends on nothing.
package bcl_pkg;

    localparam int RAM_BYTES = 32768;
    localparam int RAM_AW    = $clog2(RAM_BYTES);

    localparam int FUNC_W = 2;
    localparam int ADDR_W = 16;
    localparam int OFFS_W = 15;
    localparam int DATA_W = 8;
    localparam int SEC_W  = 6;
    localparam int MIN_W  = 6;
    localparam int HOUR_W = 5;
    localparam int DAY_W  = 9;
    localparam int ROM_W  = 7;
    localparam int BANK_W = 2;
    localparam int SEL_W  = 3;

    localparam logic [FUNC_W-1:0] FUNC_CTRL  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

    localparam logic [1:0] REGION_RAM_EN = 2'd0;
    localparam logic [1:0] REGION_ROM    = 2'd1;
    localparam logic [1:0] REGION_BANK   = 2'd2;
    localparam logic [1:0] REGION_LATCH  = 2'd3;

    localparam logic [3:0]        RAM_EN_KEY  = 4'hA;
    localparam logic [DATA_W-1:0] BANK_MAX    = 8'h03;
    localparam logic [DATA_W-1:0] CLK_SEL_LO  = 8'h08;
    localparam logic [DATA_W-1:0] CLK_SEL_HI  = 8'h0C;
    localparam logic [DATA_W-1:0] LATCH_ARM   = 8'h00;
    localparam logic [DATA_W-1:0] LATCH_FIRE  = 8'h01;

    localparam logic [SEL_W-1:0] CLK_SECONDS = 3'd0;
    localparam logic [SEL_W-1:0] CLK_MINUTES = 3'd1;
    localparam logic [SEL_W-1:0] CLK_HOURS   = 3'd2;
    localparam logic [SEL_W-1:0] CLK_DAY_LO  = 3'd3;
    localparam logic [SEL_W-1:0] CLK_DAY_HI  = 3'd4;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [SEC_W-1:0]  now_seconds;
        logic [MIN_W-1:0]  now_minutes;
        logic [HOUR_W-1:0] now_hours;
        logic [DAY_W-1:0]  now_day;
    } t_ctrl_wr;

    typedef struct packed {
        logic [ROM_W-1:0]  prg_bank;
        logic [BANK_W-1:0] sram_bank;
        logic              ram_enabled;
        logic              clock_mapped;
        logic [DATA_W-1:0] clock_byte;
    } t_ctrl_status;

endpackage

@@ rtl/bcl_if.sv @@
// Channel interfaces for the bank controller: bus access in, result out.
// Depends on bcl_pkg.
interface bcl_in_if;
    logic                        valid;
    logic                        ready;
    logic [bcl_pkg::FUNC_W-1:0]  func;
    logic [bcl_pkg::ADDR_W-1:0]  bus_address;
    logic [bcl_pkg::OFFS_W-1:0]  ram_offset;
    logic [bcl_pkg::DATA_W-1:0]  data;
    logic [bcl_pkg::SEC_W-1:0]   now_seconds;
    logic [bcl_pkg::MIN_W-1:0]   now_minutes;
    logic [bcl_pkg::HOUR_W-1:0]  now_hours;
    logic [bcl_pkg::DAY_W-1:0]   now_day;

    modport source (output valid, func, bus_address, ram_offset, data,
                    now_seconds, now_minutes, now_hours, now_day, input ready);
    modport sink   (input valid, func, bus_address, ram_offset, data,
                    now_seconds, now_minutes, now_hours, now_day, output ready);
endinterface

interface bcl_out_if;
    logic                        valid;
    logic                        ready;
    logic [bcl_pkg::DATA_W-1:0]  read_data;
    logic [bcl_pkg::ROM_W-1:0]   rom_bank_out;
    logic [bcl_pkg::BANK_W-1:0]  ram_bank_out;
    logic                        ram_enabled_out;
    logic                        clock_selected_out;

    modport source (output valid, read_data, rom_bank_out, ram_bank_out,
                    ram_enabled_out, clock_selected_out, input ready);
    modport sink   (input valid, read_data, rom_bank_out, ram_bank_out,
                    ram_enabled_out, clock_selected_out, output ready);
endinterface

@@ rtl/bcl_ram.sv @@
// Generic single-port synchronous RAM with registered read.
// Depends on nothing.
module bcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bcl_ctrl.sv @@
// Control register file: bank selects, RAM enable, clock latch detector
// and latched time fields. Depends on bcl_pkg.
module bcl_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bcl_pkg::t_ctrl_wr     i_wr,
    output bcl_pkg::t_ctrl_status o_status
);

    logic [bcl_pkg::ROM_W-1:0]  r_prg_bank,  n_prg_bank;
    logic [bcl_pkg::BANK_W-1:0] r_sram_bank, n_sram_bank;
    logic                       r_ram_en,    n_ram_en;
    logic                       r_clk_map,   n_clk_map;
    logic [bcl_pkg::SEL_W-1:0]  r_clk_sel,   n_clk_sel;
    logic                       r_armed,     n_armed;
    logic [bcl_pkg::SEC_W-1:0]  r_seconds,   n_seconds;
    logic [bcl_pkg::MIN_W-1:0]  r_minutes,   n_minutes;
    logic [bcl_pkg::HOUR_W-1:0] r_hours,     n_hours;
    logic [bcl_pkg::DAY_W-1:0]  r_day,       n_day;
    logic [bcl_pkg::DATA_W-1:0] clock_byte;

    always_comb begin
        n_prg_bank  = r_prg_bank;
        n_sram_bank = r_sram_bank;
        n_ram_en    = r_ram_en;
        n_clk_map   = r_clk_map;
        n_clk_sel   = r_clk_sel;
        n_armed     = r_armed;
        n_seconds   = r_seconds;
        n_minutes   = r_minutes;
        n_hours     = r_hours;
        n_day       = r_day;
        if (i_wr.valid && !i_wr.addr[bcl_pkg::ADDR_W-1]) begin
            case (i_wr.addr[bcl_pkg::ADDR_W-2 -: 2])
                bcl_pkg::REGION_RAM_EN: begin
                    n_ram_en = (i_wr.data[3:0] == bcl_pkg::RAM_EN_KEY);
                end
                bcl_pkg::REGION_ROM: begin
                    n_prg_bank = i_wr.data[bcl_pkg::ROM_W-1:0];
                end
                bcl_pkg::REGION_BANK: begin
                    if (i_wr.data <= bcl_pkg::BANK_MAX) begin
                        n_sram_bank = i_wr.data[bcl_pkg::BANK_W-1:0];
                        n_clk_map   = 1'b0;
                    end else if (i_wr.data >= bcl_pkg::CLK_SEL_LO &&
                                 i_wr.data <= bcl_pkg::CLK_SEL_HI) begin
                        n_clk_map = 1'b1;
                        n_clk_sel = bcl_pkg::SEL_W'(i_wr.data - bcl_pkg::CLK_SEL_LO);
                    end
                end
                bcl_pkg::REGION_LATCH: begin
                    if (i_wr.data == bcl_pkg::LATCH_ARM) begin
                        n_armed = 1'b1;
                    end else begin
                        n_armed = 1'b0;
                        if (r_armed && i_wr.data == bcl_pkg::LATCH_FIRE) begin
                            n_seconds = i_wr.now_seconds;
                            n_minutes = i_wr.now_minutes;
                            n_hours   = i_wr.now_hours;
                            n_day     = i_wr.now_day;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_bank  <= '0;
            r_sram_bank <= '0;
            r_ram_en    <= 1'b0;
            r_clk_map   <= 1'b0;
            r_clk_sel   <= '0;
            r_armed     <= 1'b0;
            r_seconds   <= '0;
            r_minutes   <= '0;
            r_hours     <= '0;
            r_day       <= '0;
        end else begin
            r_prg_bank  <= n_prg_bank;
            r_sram_bank <= n_sram_bank;
            r_ram_en    <= n_ram_en;
            r_clk_map   <= n_clk_map;
            r_clk_sel   <= n_clk_sel;
            r_armed     <= n_armed;
            r_seconds   <= n_seconds;
            r_minutes   <= n_minutes;
            r_hours     <= n_hours;
            r_day       <= n_day;
        end
    end

    always_comb begin
        case (r_clk_sel)
            bcl_pkg::CLK_SECONDS: clock_byte = bcl_pkg::DATA_W'(r_seconds);
            bcl_pkg::CLK_MINUTES: clock_byte = bcl_pkg::DATA_W'(r_minutes);
            bcl_pkg::CLK_HOURS:   clock_byte = bcl_pkg::DATA_W'(r_hours);
            bcl_pkg::CLK_DAY_LO:  clock_byte = r_day[bcl_pkg::DATA_W-1:0];
            bcl_pkg::CLK_DAY_HI:  clock_byte = bcl_pkg::DATA_W'(r_day[bcl_pkg::DAY_W-1]);
            default:              clock_byte = '0;
        endcase
    end

    assign o_status.prg_bank     = r_prg_bank;
    assign o_status.sram_bank    = r_sram_bank;
    assign o_status.ram_enabled  = r_ram_en;
    assign o_status.clock_mapped = r_clk_map;
    assign o_status.clock_byte   = clock_byte;

endmodule

@@ rtl/bank_controller_with_clock_latch_top.sv @@
// Bank controller with clock latch, top level.
// Path: RAM read and stage-1 registers, then the output register, from input transfer to result transfer.
// Throughput: one transfer per cycle while the output is not stalled; set by the single RAM port, one access per item.
// Reset: synchronous active low; clears control registers and pipeline valids.
// RAM contents are not cleared; unwritten bytes read as unknown.
// Depends on bcl_pkg, bcl_if, bcl_ram, bcl_ctrl.
module bank_controller_with_clock_latch_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bcl_in_if.sink    i_in,
    bcl_out_if.source o_out
);

    localparam int EXT_W = bcl_pkg::RAM_AW + bcl_pkg::OFFS_W;

    logic                        accept;
    logic                        s1_advance;
    logic [EXT_W-1:0]            offs_ext;
    logic [bcl_pkg::RAM_AW-1:0]  ram_addr;
    logic [bcl_pkg::DATA_W-1:0]  ram_rdata;
    logic                        is_read;
    logic                        is_write;
    bcl_pkg::t_ctrl_wr           ctrl_wr;
    bcl_pkg::t_ctrl_status       status;

    logic                        r_s1_valid;
    logic                        r_s1_read;
    logic                        r_s1_clk;
    logic [bcl_pkg::DATA_W-1:0]  r_s1_clk_byte;

    logic                        r_out_valid;
    logic [bcl_pkg::DATA_W-1:0]  r_out_rdata;
    logic [bcl_pkg::ROM_W-1:0]   r_out_prg_bank;
    logic [bcl_pkg::BANK_W-1:0]  r_out_sram_bank;
    logic                        r_out_ram_en;
    logic                        r_out_clk_map;

    assign s1_advance = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_advance;
    assign accept     = i_in.valid && i_in.ready;

    assign is_read  = (i_in.func == bcl_pkg::FUNC_READ);
    assign is_write = (i_in.func == bcl_pkg::FUNC_WRITE);
    assign offs_ext = EXT_W'(i_in.ram_offset);
    assign ram_addr = offs_ext[bcl_pkg::RAM_AW-1:0];

    assign ctrl_wr.valid       = accept && (i_in.func == bcl_pkg::FUNC_CTRL);
    assign ctrl_wr.addr        = i_in.bus_address;
    assign ctrl_wr.data        = i_in.data;
    assign ctrl_wr.now_seconds = i_in.now_seconds;
    assign ctrl_wr.now_minutes = i_in.now_minutes;
    assign ctrl_wr.now_hours   = i_in.now_hours;
    assign ctrl_wr.now_day     = i_in.now_day;

    bcl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (ctrl_wr),
        .o_status (status)
    );

    bcl_ram #(
        .WIDTH (bcl_pkg::DATA_W),
        .DEPTH (bcl_pkg::RAM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (accept && (is_read || is_write)),
        .i_we    (is_write),
        .i_addr  (ram_addr),
        .i_wdata (i_in.data),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // capture clock field with pre-step state; a read leaves it unchanged
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_read     <= is_read;
            r_s1_clk      <= status.clock_mapped;
            r_s1_clk_byte <= status.clock_byte;
        end
        if (s1_advance) begin
            r_out_prg_bank  <= status.prg_bank;
            r_out_sram_bank <= status.sram_bank;
            r_out_ram_en    <= status.ram_enabled;
            r_out_clk_map   <= status.clock_mapped;
            if (!r_s1_read) begin
                r_out_rdata <= '0;
            end else if (r_s1_clk) begin
                r_out_rdata <= r_s1_clk_byte;
            end else begin
                r_out_rdata <= ram_rdata;
            end
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.read_data          = r_out_rdata;
    assign o_out.rom_bank_out       = r_out_prg_bank;
    assign o_out.ram_bank_out       = r_out_sram_bank;
    assign o_out.ram_enabled_out    = r_out_ram_en;
    assign o_out.clock_selected_out = r_out_clk_map;

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_advance) |-> !i_in.ready)
        else $error("input taken while stage 1 is stalled");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance |=> r_out_valid)
        else $error("stage 1 transfer lost before output register");

    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_advance && !r_s1_read) |=> (o_out.read_data == '0))
        else $error("non-read item returned nonzero read data");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted transfer did not enter stage 1");
`endif

endmodule
